// ===== design/elhv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhv_pkg
// Shared widths, register indexes, reset values and helpers for the tank
// level hysteresis valve controller.
// ----------------------------------------------------------------------------
package elhv_pkg;

  localparam int ECHO_W     = 14;
  localparam int HEIGHT_W   = 16;
  localparam int SERVO_W    = 10;
  localparam int DUTY_W     = 8;
  localparam int LEVEL_W    = 19;
  localparam int DIST_W     = 18;
  localparam int SUM_W      = 20;
  localparam int WIDE_W     = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // distance = ticks * 12588 >> 10, 1/256 cm
  localparam int DIST_MULT  = 12588;
  localparam int DIST_SHIFT = 10;
  localparam int DIST_PROD_W = ECHO_W + 14;

  localparam int SAMPLES_DEF   = 5;
  localparam int ECHO_BITS_DEF = 14;

  localparam logic [HEIGHT_W-1:0] TANK_HEIGHT_RST  = 16'd6656;
  localparam logic [HEIGHT_W-1:0] OPEN_DIST_RST    = 16'd1792;
  localparam logic [HEIGHT_W-1:0] CLOSE_DIST_RST   = 16'd5120;
  localparam logic [SERVO_W-1:0]  SERVO_OPEN_RST   = 10'd75;
  localparam logic [SERVO_W-1:0]  SERVO_CLOSED_RST = 10'd125;
  localparam logic [DUTY_W-1:0]   BUZZER_DUTY_RST  = 8'd240;

  localparam logic signed [WIDE_W-1:0] LEVEL_HI = 21'sd262143;
  localparam logic signed [WIDE_W-1:0] LEVEL_LO = -21'sd262144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TANK_HEIGHT        = 3'd0,
    REG_OPEN_DISTANCE      = 3'd1,
    REG_CLOSE_DISTANCE     = 3'd2,
    REG_SERVO_OPEN_PULSE   = 3'd3,
    REG_SERVO_CLOSED_PULSE = 3'd4,
    REG_BUZZER_ON_DUTY     = 3'd5
  } cfg_reg_t;

  function automatic logic signed [LEVEL_W-1:0] sat_level(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [LEVEL_W-1:0] r;
    if (v > LEVEL_HI) begin
      r = LEVEL_HI[LEVEL_W-1:0];
    end else if (v < LEVEL_LO) begin
      r = LEVEL_LO[LEVEL_W-1:0];
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/elhv_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhv_cfg_if
// Register write channel: valid/ready, register index and write data.
// ----------------------------------------------------------------------------
interface elhv_cfg_if;
  import elhv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/elhv_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhv_in_if
// Sample channel: echo measurement or manual open request.
// ----------------------------------------------------------------------------
interface elhv_in_if;
  import elhv_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ECHO_W-1:0] echo_ticks;

  modport source(output valid, req_type, echo_ticks, input ready);
  modport sink(input valid, req_type, echo_ticks, output ready);
endinterface

// ===== design/elhv_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhv_out_if
// Result channel: levels, average flag and actuator state.
// ----------------------------------------------------------------------------
interface elhv_out_if;
  import elhv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [LEVEL_W-1:0]  level;
  logic                       avg_valid;
  logic signed [LEVEL_W-1:0]  avg_level;
  logic                       valve_open;
  logic [SERVO_W-1:0]         servo_pulse;
  logic [DUTY_W-1:0]          buzzer_duty;
  logic                       leds_on;

  modport source(
    output valid, level, avg_valid, avg_level, valve_open, servo_pulse,
           buzzer_duty, leds_on,
    input  ready
  );
  modport sink(
    input  valid, level, avg_valid, avg_level, valve_open, servo_pulse,
           buzzer_duty, leds_on,
    output ready
  );
endinterface

// ===== design/echo_level_hysteresis_valve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_level_hysteresis_valve
// Tank level controller: echo width to distance and level, block average,
// hysteresis valve / LED / buzzer control.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  cfg      | in  | valid/ready   | index, data (always ready)
//  sample   | in  | valid/ready   | req_type, echo_ticks
//  result   | out | valid/ready   | level, avg_valid, avg_level, valve_open,
//           |     |               | servo_pulse, buzzer_duty, leds_on
//
//  One item per cycle sustained while result.ready is high.
//  Stage 1 registers the distance product, stage 2 does sum, reciprocal
//  average multiply and threshold compares into the result register.
//  rst is synchronous: config returns to defaults, valve closed, block empty.
//  A stalled result holds the pipe; sample.ready falls only when both stages
//  are full and result.ready is low.
// ----------------------------------------------------------------------------
module echo_level_hysteresis_valve #(
  parameter int SAMPLES_PER_AVERAGE = elhv_pkg::SAMPLES_DEF,
  parameter int ECHO_BITS           = elhv_pkg::ECHO_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  elhv_cfg_if.sink    cfg,
  elhv_in_if.sink     sample,
  elhv_out_if.source  result
);
  import elhv_pkg::*;

  localparam int CNT_W      = $clog2(SAMPLES_PER_AVERAGE);
  localparam int RECIP_SH   = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam int PROD_W     = SUM_W + WIDE_W;
  localparam longint unsigned RecipL =
    ((64'd1 << RECIP_SH) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);
  localparam logic [PROD_W-1:0] RECIP = PROD_W'(RecipL);
  localparam longint unsigned EchoMaxL = (64'd1 << ECHO_BITS) - 64'd1;
  localparam logic [16:0] ECHO_MAX = 17'(EchoMaxL);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  // config registers
  logic [HEIGHT_W-1:0] tank_height;
  logic [HEIGHT_W-1:0] open_distance;
  logic [HEIGHT_W-1:0] close_distance;
  logic [SERVO_W-1:0]  servo_open_pulse;
  logic [SERVO_W-1:0]  servo_closed_pulse;
  logic [DUTY_W-1:0]   buzzer_on_duty;

  // controller state
  logic [CNT_W-1:0]    sample_count, sample_count_next;
  logic [SUM_W-1:0]    distance_sum, distance_sum_next;
  logic                valve_state, valve_state_next;
  logic                led_state, led_state_next;
  logic [SERVO_W-1:0]  servo_value, servo_value_next;
  logic [DUTY_W-1:0]   buzzer_value, buzzer_value_next;

  // stage 1
  logic                s1_valid;
  logic                s1_manual;
  logic [DIST_W-1:0]   s1_dist;

  // result register
  logic                      out_valid;
  logic signed [LEVEL_W-1:0] out_level, level_next;
  logic                      out_avg_valid, avg_valid_next;
  logic signed [LEVEL_W-1:0] out_avg_level, avg_level_next;

  logic                   advance;
  logic                   s2_fire;
  logic [ECHO_W-1:0]      ticks;
  logic [DIST_PROD_W-1:0] dist_prod;
  logic [WIDE_W-1:0]      sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic [PROD_W-1:0]      avg_prod;
  logic [SUM_W-1:0]       avg;
  logic                   open_hit;
  logic                   close_hit;

  assign advance      = !out_valid || result.ready;
  assign s2_fire      = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  // ticks to distance
  always_comb begin
    if ({3'b0, sample.echo_ticks} > ECHO_MAX) begin
      ticks = ECHO_MAX[ECHO_W-1:0];
    end else begin
      ticks = sample.echo_ticks;
    end
    dist_prod = DIST_PROD_W'(ticks) * DIST_PROD_W'(DIST_MULT);
  end

  // sum, average and hysteresis decision
  always_comb begin
    sum_wide = {1'b0, distance_sum} + WIDE_W'(s1_dist);
    sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    avg_prod = PROD_W'(sum_sat) * RECIP;
    avg      = SUM_W'(avg_prod >> RECIP_SH);
    open_hit  = avg <= {{(SUM_W-HEIGHT_W){1'b0}}, open_distance};
    close_hit = avg >= {{(SUM_W-HEIGHT_W){1'b0}}, close_distance};

    sample_count_next = sample_count;
    distance_sum_next = distance_sum;
    valve_state_next  = valve_state;
    led_state_next    = led_state;
    servo_value_next  = servo_value;
    buzzer_value_next = buzzer_value;
    level_next        = '0;
    avg_valid_next    = 1'b0;
    avg_level_next    = '0;

    if (s1_manual) begin
      valve_state_next  = 1'b1;
      servo_value_next  = servo_open_pulse;
      buzzer_value_next = buzzer_on_duty;
    end else begin
      level_next = sat_level($signed({{(WIDE_W-HEIGHT_W){1'b0}}, tank_height})
                           - $signed({{(WIDE_W-DIST_W){1'b0}}, s1_dist}));
      if (sample_count >= LAST_CNT) begin
        avg_valid_next = 1'b1;
        avg_level_next = sat_level($signed({{(WIDE_W-HEIGHT_W){1'b0}}, tank_height})
                                 - $signed({1'b0, avg}));
        if (open_hit) begin
          valve_state_next  = 1'b1;
          led_state_next    = 1'b1;
          servo_value_next  = servo_open_pulse;
          buzzer_value_next = buzzer_on_duty;
        end
        if (close_hit) begin
          valve_state_next  = 1'b0;
          led_state_next    = 1'b0;
          servo_value_next  = servo_closed_pulse;
          buzzer_value_next = '0;
        end
        distance_sum_next = '0;
        sample_count_next = '0;
      end else begin
        distance_sum_next = sum_sat;
        sample_count_next = sample_count + 1'b1;
      end
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tank_height        <= TANK_HEIGHT_RST;
      open_distance      <= OPEN_DIST_RST;
      close_distance     <= CLOSE_DIST_RST;
      servo_open_pulse   <= SERVO_OPEN_RST;
      servo_closed_pulse <= SERVO_CLOSED_RST;
      buzzer_on_duty     <= BUZZER_DUTY_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_TANK_HEIGHT:        tank_height        <= cfg.data;
        REG_OPEN_DISTANCE:      open_distance      <= cfg.data;
        REG_CLOSE_DISTANCE:     close_distance     <= cfg.data;
        REG_SERVO_OPEN_PULSE:   servo_open_pulse   <= cfg.data[SERVO_W-1:0];
        REG_SERVO_CLOSED_PULSE: servo_closed_pulse <= cfg.data[SERVO_W-1:0];
        REG_BUZZER_ON_DUTY:     buzzer_on_duty     <= cfg.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_manual <= sample.req_type;
      s1_dist   <= dist_prod[DIST_SHIFT +: DIST_W];
    end
  end

  // stage 2: state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      sample_count <= '0;
      distance_sum <= '0;
      valve_state  <= 1'b0;
      led_state    <= 1'b0;
      servo_value  <= '0;
      buzzer_value <= '0;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s2_fire) begin
        sample_count <= sample_count_next;
        distance_sum <= distance_sum_next;
        valve_state  <= valve_state_next;
        led_state    <= led_state_next;
        servo_value  <= servo_value_next;
        buzzer_value <= buzzer_value_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_level     <= level_next;
      out_avg_valid <= avg_valid_next;
      out_avg_level <= avg_level_next;
    end
  end

  // actuator state only moves when a new result is loaded
  assign result.valid       = out_valid;
  assign result.level       = out_level;
  assign result.avg_valid   = out_avg_valid;
  assign result.avg_level   = out_avg_level;
  assign result.valve_open  = valve_state;
  assign result.servo_pulse = servo_value;
  assign result.buzzer_duty = buzzer_value;
  assign result.leds_on     = led_state;

endmodule

// ===== design/elhv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elhv_checker
// Port-level checks for the level controller, bound to the top level.
// ----------------------------------------------------------------------------
module elhv_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [elhv_pkg::LEVEL_W-1:0]   level,
  input logic                                  avg_valid,
  input logic signed [elhv_pkg::LEVEL_W-1:0]   avg_level,
  input logic                                  valve_open,
  input logic [elhv_pkg::DUTY_W-1:0]           buzzer_duty,
  input logic                                  leds_on
);
  import elhv_pkg::*;

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(avg_valid)
      && $stable(avg_level))
    else $error("result changed while stalled");

  // closed valve means a silent buzzer
  a_closed_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valve_open |-> buzzer_duty == '0)
    else $error("buzzer on with valve closed");

  // LEDs only come on with an open valve
  a_leds_valve: assert property (@(posedge clk) disable iff (rst)
    out_valid && leds_on |-> valve_open)
    else $error("LEDs lit with valve closed");

  // no average outside a completed block
  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !avg_valid |-> avg_level == '0)
    else $error("avg_level nonzero without avg_valid");

endmodule

bind echo_level_hysteresis_valve elhv_checker u_elhv_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .level       (result.level),
  .avg_valid   (result.avg_valid),
  .avg_level   (result.avg_level),
  .valve_open  (result.valve_open),
  .buzzer_duty (result.buzzer_duty),
  .leds_on     (result.leds_on)
);
